>>> sv/lr_pkg.sv
package lr_pkg;

	localparam int COLOR_BITS  = 32;
	localparam int DIM_BITS    = 13;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_kind_t;

	typedef enum logic {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Queue entry, lowest bit up: kind, steep, major_pos, minor_pos, major_stop,
	// major_delta, minor_delta_abs, minor_neg, color
	function automatic int entry_bits(input int coord_bits);
		return 5 * coord_bits + COLOR_BITS + 5;
	endfunction

endpackage

>>> sv/lr_queue.sv
module lr_queue #(
	parameter int WIDTH = 97,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q != '0))
		else $error("queue empty after push");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers apart while empty");

endmodule

>>> sv/lr_front.sv
module lr_front #(
	parameter int COORD_BITS = 12
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           in_valid,
	output logic                                           in_ready,
	input  lr_pkg::req_kind_t                              in_kind,
	input  logic signed [COORD_BITS-1:0]                   in_x1,
	input  logic signed [COORD_BITS-1:0]                   in_y1,
	input  logic signed [COORD_BITS-1:0]                   in_x2,
	input  logic signed [COORD_BITS-1:0]                   in_y2,
	input  logic [lr_pkg::COLOR_BITS-1:0]                  in_color,
	output logic                                           push_valid,
	input  logic                                           push_ready,
	output logic [lr_pkg::entry_bits(COORD_BITS)-1:0]      push_data
);
	import lr_pkg::*;

	localparam int C = COORD_BITS;

	logic                  valid_s1;
	req_kind_t             kind_s1;
	logic signed [C-1:0]   x1_s1;
	logic signed [C-1:0]   y1_s1;
	logic signed [C-1:0]   x2_s1;
	logic signed [C-1:0]   y2_s1;
	logic [COLOR_BITS-1:0] color_s1;

	logic signed [C:0]     dx;
	logic signed [C:0]     dy;
	logic [C:0]            adx;
	logic [C:0]            ady;
	logic                  steep;
	logic                  swap;
	logic [C-1:0]          major_pos;
	logic [C-1:0]          minor_pos;
	logic [C-1:0]          major_stop;
	logic [C:0]            major_delta;
	logic [C:0]            minor_abs;
	logic                  minor_neg;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= in_kind;
			x1_s1    <= in_x1;
			y1_s1    <= in_y1;
			x2_s1    <= in_x2;
			y2_s1    <= in_y2;
			color_s1 <= in_color;
		end
	end

	// Classify the line: axis choice, endpoint order, deltas and minor direction
	always_comb begin
		dx        = {x2_s1[C-1], x2_s1} - {x1_s1[C-1], x1_s1};
		dy        = {y2_s1[C-1], y2_s1} - {y1_s1[C-1], y1_s1};
		adx       = dx[C] ? $unsigned(-dx) : $unsigned(dx);
		ady       = dy[C] ? $unsigned(-dy) : $unsigned(dy);
		steep     = (dx == '0) || (adx < ady);
		swap      = steep ? dy[C] : dx[C];
		minor_neg = dx[C] ^ dy[C];
		if (steep) begin
			major_pos   = swap ? y2_s1 : y1_s1;
			major_stop  = swap ? y1_s1 : y2_s1;
			minor_pos   = swap ? x2_s1 : x1_s1;
			major_delta = ady;
			minor_abs   = adx;
		end else begin
			major_pos   = swap ? x2_s1 : x1_s1;
			major_stop  = swap ? x1_s1 : x2_s1;
			minor_pos   = swap ? y2_s1 : y1_s1;
			major_delta = adx;
			minor_abs   = ady;
		end
	end

	assign push_data = {color_s1, minor_neg, minor_abs, major_delta, major_stop,
		minor_pos, major_pos, steep, kind_s1};

endmodule

>>> sv/lr_back.sv
module lr_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      q_valid,
	output logic                                      q_ready,
	input  logic [lr_pkg::entry_bits(COORD_BITS)-1:0] q_data,
	input  logic [lr_pkg::DIM_BITS-1:0]               image_width,
	input  logic [lr_pkg::DIM_BITS-1:0]               image_height,
	output logic                                      pix_valid,
	input  logic                                      pix_ready,
	output logic signed [COORD_BITS-1:0]              pixel_x,
	output logic signed [COORD_BITS-1:0]              pixel_y,
	output logic [lr_pkg::COLOR_BITS-1:0]             pixel_color,
	output logic                                      inside_res,
	output logic                                      last
);
	import lr_pkg::*;

	localparam int C = COORD_BITS;
	localparam int E = C + 3;
	localparam int W = (C > DIM_BITS) ? C : DIM_BITS;

	req_kind_t             head_kind;
	logic                  active_q;
	logic                  steep_q;
	logic signed [C-1:0]   major_pos_q;
	logic signed [C-1:0]   minor_pos_q;
	logic signed [C-1:0]   major_stop_q;
	logic signed [E-1:0]   err_q;
	logic [C:0]            major_delta_q;
	logic [C:0]            minor_abs_q;
	logic                  minor_neg_q;
	logic [COLOR_BITS-1:0] color_q;

	logic                  pix_valid_q;
	logic [C-1:0]          pixel_x_q;
	logic [C-1:0]          pixel_y_q;
	logic [COLOR_BITS-1:0] pixel_color_q;
	logic                  inside_q;
	logic                  last_q;

	logic                  can_emit;
	logic                  do_pop;
	logic                  do_load;
	logic                  do_step;
	logic                  is_last;
	logic [C-1:0]          px;
	logic [C-1:0]          py;
	logic                  in_bounds;
	logic signed [E-1:0]   two_m;
	logic signed [E-1:0]   two_d;
	logic signed [E-1:0]   err_add;
	logic signed [E-1:0]   err_sub;

	assign head_kind = req_kind_t'(q_data[0]);
	assign can_emit  = !pix_valid_q || pix_ready;
	assign q_ready   = can_emit;
	assign do_pop    = q_valid && can_emit;
	assign do_load   = do_pop && (head_kind == REQ_START);
	assign do_step   = do_pop && (head_kind == REQ_STEP) && active_q;

	always_comb begin
		is_last   = (major_pos_q >= major_stop_q);
		px        = steep_q ? minor_pos_q : major_pos_q;
		py        = steep_q ? major_pos_q : minor_pos_q;
		in_bounds = !px[C-1] && (W'(px) < W'(image_width)) &&
			!py[C-1] && (W'(py) < W'(image_height));
		two_m     = $signed({1'b0, minor_abs_q, 1'b0});
		two_d     = $signed({1'b0, major_delta_q, 1'b0});
		err_add   = err_q + two_m;
		err_sub   = err_add - two_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			steep_q       <= 1'b0;
			major_pos_q   <= '0;
			minor_pos_q   <= '0;
			major_stop_q  <= '0;
			err_q         <= '0;
			major_delta_q <= '0;
			minor_abs_q   <= '0;
			minor_neg_q   <= 1'b0;
			color_q       <= '0;
		end else if (do_load) begin
			active_q      <= 1'b1;
			steep_q       <= q_data[1];
			major_pos_q   <= q_data[2 +: C];
			minor_pos_q   <= q_data[2 + C +: C];
			major_stop_q  <= q_data[2 + 2 * C +: C];
			major_delta_q <= q_data[2 + 3 * C +: C + 1];
			minor_abs_q   <= q_data[3 + 4 * C +: C + 1];
			minor_neg_q   <= q_data[4 + 5 * C];
			color_q       <= q_data[5 + 5 * C +: COLOR_BITS];
			err_q         <= -$signed({2'b00, q_data[2 + 3 * C +: C + 1]});
		end else if (do_step) begin
			if (is_last) begin
				active_q <= 1'b0;
			end else begin
				major_pos_q <= major_pos_q + 1'b1;
				if (err_add > 0) begin
					err_q       <= err_sub;
					minor_pos_q <= minor_neg_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
				end else begin
					err_q <= err_add;
				end
			end
		end
	end

	// Output register: hold the pixel until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (can_emit) begin
			pix_valid_q <= do_step;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			pixel_x_q     <= px;
			pixel_y_q     <= py;
			pixel_color_q <= color_q;
			inside_q      <= in_bounds;
			last_q        <= is_last;
		end
	end

	assign pix_valid   = pix_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign inside_res  = inside_q;
	assign last        = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (err_q <= 0))
		else $error("error term positive between pixels");

	assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (major_pos_q <= major_stop_q))
		else $error("walk passed its end");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_step && is_last) |=> !active_q)
		else $error("line still active after last pixel");

endmodule

>>> sv/line_rasterizer.sv
// Data path: input stage register, queue write, walker into the output register.
// Throughput: one request per cycle unless the output stalls; the walker updates
// its position and error register once per pixel. A 4-entry queue decouples intake
// from the walker.
// Reset (arst_n low, asynchronous): no line active, queue and output empty,
// image_width 640, image_height 480.
module line_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	// x_start, y_start, x_end, y_end, line_color, zero fill
	input  logic [((4*COORD_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
	// req_type
	input  logic                                          s_axis_tuser,
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	// pixel_x, pixel_y, pixel_color, zero fill
	output logic [((2*COORD_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
	// inside_res
	output logic                                          m_axis_tuser,
	output logic                                          m_axis_tlast,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic                                          cfg_index,
	input  logic [lr_pkg::DIM_BITS-1:0]                   cfg_data
);
	import lr_pkg::*;

	localparam int C       = COORD_BITS;
	localparam int ENTRY_W = entry_bits(COORD_BITS);
	localparam int OUT_W   = ((2 * C + COLOR_BITS + 7) / 8) * 8;

	logic [DIM_BITS-1:0]   width_q;
	logic [DIM_BITS-1:0]   height_q;

	logic                  push_valid;
	logic                  push_ready;
	logic [ENTRY_W-1:0]    push_data;
	logic                  pop_valid;
	logic                  pop_ready;
	logic [ENTRY_W-1:0]    pop_data;

	logic signed [C-1:0]   pixel_x;
	logic signed [C-1:0]   pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_kind    (req_kind_t'(s_axis_tuser)),
		.in_x1      (s_axis_tdata[0 +: C]),
		.in_y1      (s_axis_tdata[C +: C]),
		.in_x2      (s_axis_tdata[2 * C +: C]),
		.in_y2      (s_axis_tdata[3 * C +: C]),
		.in_color   (s_axis_tdata[4 * C +: COLOR_BITS]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lr_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (pop_valid),
		.q_ready      (pop_ready),
		.q_data       (pop_data),
		.image_width  (width_q),
		.image_height (height_q),
		.pix_valid    (m_axis_tvalid),
		.pix_ready    (m_axis_tready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.inside_res   (m_axis_tuser),
		.last         (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_W'({pixel_color, pixel_y, pixel_x});

endmodule

>>> verif/line_rasterizer_tb.sv
`timescale 1ns / 100ps

module line_rasterizer_tb;
	import lr_pkg::*;

	localparam int COORD_BITS = 12;
	localparam int IN_BITS    = ((4*COORD_BITS + COLOR_BITS + 7)/8)*8;
	localparam int OUT_BITS   = ((2*COORD_BITS + COLOR_BITS + 7)/8)*8;
	localparam int COORD_MIN  = -(1 << (COORD_BITS-1));
	localparam int COORD_MAX  = (1 << (COORD_BITS-1)) - 1;

	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0]        color;
		logic                         in_bounds;
		logic                         last;
	} pixel_t;

	function automatic int iabs(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp_coord(int v);
		if (v < COORD_MIN) return COORD_MIN;
		if (v > COORD_MAX) return COORD_MAX;
		return v;
	endfunction

	// Walks the current line the way the engine should and keeps the pixels
	// it still owes, oldest first.
	class line_walker;
		logic                         active;
		logic                         steep;
		logic signed [COORD_BITS-1:0] major_pos;
		logic signed [COORD_BITS-1:0] minor_pos;
		logic signed [COORD_BITS-1:0] major_stop;
		logic signed [COORD_BITS+2:0] err_acc;
		logic [COORD_BITS:0]          major_span;
		logic [COORD_BITS:0]          minor_span;
		logic signed [1:0]            minor_step;
		logic [COLOR_BITS-1:0]        color;
		logic [DIM_BITS-1:0]          image_width;
		logic [DIM_BITS-1:0]          image_height;
		pixel_t                       pending[$];
		int                           mismatches;

		function new();
			active       = 1'b0;
			steep        = 1'b0;
			major_pos    = '0;
			minor_pos    = '0;
			major_stop   = '0;
			err_acc      = '0;
			major_span   = '0;
			minor_span   = '0;
			minor_step   = '0;
			color        = '0;
			image_width  = WIDTH_RESET;
			image_height = HEIGHT_RESET;
			mismatches   = 0;
		endfunction

		function void load(int x1, int y1, int x2, int y2);
			int t;
			int d;
			if (x1 == x2) begin
				steep = 1'b1;
				if (y1 > y2) begin
					t = y1; y1 = y2; y2 = t;
				end
				major_pos  = COORD_BITS'(y1);
				major_stop = COORD_BITS'(y2);
				minor_pos  = COORD_BITS'(x1);
				major_span = (COORD_BITS+1)'(y2 - y1);
				minor_span = '0;
				minor_step = '0;
			end else if (y1 == y2) begin
				steep = 1'b0;
				if (x1 > x2) begin
					t = x1; x1 = x2; x2 = t;
				end
				major_pos  = COORD_BITS'(x1);
				major_stop = COORD_BITS'(x2);
				minor_pos  = COORD_BITS'(y1);
				major_span = (COORD_BITS+1)'(x2 - x1);
				minor_span = '0;
				minor_step = '0;
			end else begin
				steep = iabs(x2 - x1) < iabs(y2 - y1);
				// swap axes so the walk always advances along x
				if (steep) begin
					t = x1; x1 = y1; y1 = t;
					t = x2; x2 = y2; y2 = t;
				end
				if (x1 > x2) begin
					t = x1; x1 = x2; x2 = t;
					t = y1; y1 = y2; y2 = t;
				end
				d = y2 - y1;
				major_pos  = COORD_BITS'(x1);
				major_stop = COORD_BITS'(x2);
				minor_pos  = COORD_BITS'(y1);
				major_span = (COORD_BITS+1)'(x2 - x1);
				minor_span = (COORD_BITS+1)'(iabs(d));
				minor_step = 2'((d < 0) ? -1 : ((d > 0) ? 1 : 0));
			end
			err_acc = (COORD_BITS+3)'(-int'(major_span));
			active  = 1'b1;
		endfunction

		function void advance();
			pixel_t p;
			int     px;
			int     py;
			int     e;
			if (steep) begin
				px = minor_pos;
				py = major_pos;
			end else begin
				px = major_pos;
				py = minor_pos;
			end
			p.x         = COORD_BITS'(px);
			p.y         = COORD_BITS'(py);
			p.color     = color;
			p.in_bounds = px >= 0 && px < int'(image_width) &&
			              py >= 0 && py < int'(image_height);
			p.last      = major_pos >= major_stop;
			pending.push_back(p);
			if (p.last) begin
				active = 1'b0;
			end else begin
				e = err_acc + 2*int'(minor_span);
				if (e > 0) begin
					minor_pos = minor_pos + minor_step;
					e = e - 2*int'(major_span);
				end
				err_acc   = (COORD_BITS+3)'(e);
				major_pos = major_pos + 1'b1;
			end
		endfunction

		function void take_request(req_kind_t kind, logic [IN_BITS-1:0] word);
			if (kind == REQ_START) begin
				color = word[4*COORD_BITS +: COLOR_BITS];
				load($signed(word[0 +: COORD_BITS]), $signed(word[COORD_BITS +: COORD_BITS]),
				     $signed(word[2*COORD_BITS +: COORD_BITS]),
				     $signed(word[3*COORD_BITS +: COORD_BITS]));
			end else if (active) begin
				advance();
			end
		endfunction

		function void compare(string field, longint want, longint got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_pixel(logic [OUT_BITS-1:0] word, logic in_bounds, logic last);
			pixel_t want;
			if (pending.size() == 0) begin
				$display("%0t: pixel expected none actual (%0d,%0d)", $time,
				         $signed(word[0 +: COORD_BITS]),
				         $signed(word[COORD_BITS +: COORD_BITS]));
				mismatches++;
				return;
			end
			want = pending.pop_front();
			compare("pixel_x", want.x, $signed(word[0 +: COORD_BITS]));
			compare("pixel_y", want.y, $signed(word[COORD_BITS +: COORD_BITS]));
			compare("pixel_color", want.color, word[2*COORD_BITS +: COLOR_BITS]);
			compare("inside_res", want.in_bounds, in_bounds);
			compare("last", want.last, last);
		endfunction
	endclass

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                s_axis_tvalid  = 1'b0;
	logic                s_axis_tready;
	logic [IN_BITS-1:0]  s_axis_tdata   = '0;
	logic                s_axis_tuser   = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready  = 1'b0;
	logic [OUT_BITS-1:0] m_axis_tdata;
	logic                m_axis_tuser;
	logic                m_axis_tlast;
	logic                cfg_valid      = 1'b0;
	logic                cfg_ready;
	logic                cfg_index      = 1'b0;
	logic [DIM_BITS-1:0] cfg_data       = '0;
	logic                calm           = 1'b0;

	line_walker walker;

	line_rasterizer #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// alternate between stretches of random idling and stretches of none
	initial forever begin
		repeat ($urandom_range(50, 300)) @(posedge clk);
		calm <= ~calm;
	end

	function automatic int idle_cycles();
		return calm ? 0 : int'($urandom_range(0, 9));
	endfunction

	function automatic int any_coord();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		return int'($urandom_range(0, 2*COORD_MAX + 1)) + COORD_MIN;
	endfunction

	// land near the origin, near the clipping edge or anywhere
	function automatic int near_coord(int size);
		int a;
		case ($urandom_range(0, 2))
			0:       a = 0;
			1:       a = size;
			default: a = any_coord();
		endcase
		return clamp_coord(a + int'($urandom_range(0, 32)) - 16);
	endfunction

	task automatic send_request(req_kind_t kind, logic [IN_BITS-1:0] word);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		walker.take_request(kind, word);
	endtask

	task automatic send_start(int x1, int y1, int x2, int y2, logic [COLOR_BITS-1:0] color);
		send_request(REQ_START, {color, y2[COORD_BITS-1:0], x2[COORD_BITS-1:0],
		                         y1[COORD_BITS-1:0], x1[COORD_BITS-1:0]});
	endtask

	// step requests carry junk in the endpoint fields; the engine must ignore it
	task automatic send_step();
		send_request(REQ_STEP, IN_BITS'({$urandom, $urandom, $urandom}));
	endtask

	task automatic write_dims(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		walker.image_width = w;
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data  <= h;
		do @(posedge clk); while (!cfg_ready);
		walker.image_height = h;
		cfg_valid <= 1'b0;
	endtask

	// drop valid, wait out owed pixels, then let queued no-result requests drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (walker.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic run_random_lines(int budget);
		int sent;
		int x1;
		int y1;
		int x2;
		int y2;
		int steps;
		int pick;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				send_step();
				sent++;
			end else begin
				if (pick <= 2) begin
					// long line: walk a few pixels, then abandon it
					x1    = any_coord();
					y1    = any_coord();
					x2    = any_coord();
					y2    = any_coord();
					steps = $urandom_range(1, 12);
				end else begin
					x1 = near_coord(walker.image_width);
					y1 = near_coord(walker.image_height);
					x2 = clamp_coord(x1 + int'($urandom_range(0, 24)) - 12);
					y2 = clamp_coord(y1 + int'($urandom_range(0, 24)) - 12);
					case ($urandom_range(0, 7))
						0: x2 = x1;
						1: y2 = y1;
						2: begin
							x2 = x1;
							y2 = y1;
						end
						default: ;
					endcase
					steps = ((iabs(x2 - x1) > iabs(y2 - y1)) ? iabs(x2 - x1) : iabs(y2 - y1)) + 1;
					case ($urandom_range(0, 5))
						0:       steps = $urandom_range(1, steps);
						1:       steps = steps + $urandom_range(1, 2);
						default: ;
					endcase
				end
				send_start(x1, y1, x2, y2, $urandom);
				sent++;
				repeat (steps) begin
					send_step();
					sent++;
				end
			end
		end
	endtask

	initial begin : pixel_sink
		int stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			walker.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	initial begin : stimulus
		walker = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_step();
		// single-pixel line, then a step past its end
		send_start(5, 5, 5, 5, 32'h0000_0000);
		send_step();
		send_step();
		send_start(10, 20, 10, 18, 32'hFFFF_FFFF);
		repeat (3) send_step();
		send_start(2, -1, 0, -1, 32'h1234_5678);
		repeat (3) send_step();
		send_start(0, 0, -1, 3, 32'hA5A5_5A5A);
		repeat (4) send_step();
		// restart while a long line is still running
		send_start(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 32'hFFFF_FFFF);
		repeat (2) send_step();
		send_start(638, 478, 641, 480, 32'h8000_0001);
		repeat (4) send_step();
		settle();

		run_random_lines(80);
		settle();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       write_dims(DIM_BITS'(0), DIM_BITS'(0));
				1:       write_dims(DIM_BITS'(4096), DIM_BITS'(4096));
				2:       write_dims(DIM_BITS'(1), DIM_BITS'(2047));
				default: write_dims(DIM_BITS'($urandom_range(2, 4095)),
				                    DIM_BITS'($urandom_range(2, 4095)));
			endcase
			run_random_lines(80);
			settle();
		end

		if (walker.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
